>>> hw/rtl/rpc_pkg.sv
// rpc_pkg: shared types and constants for the reverse pair coder.
// Holds the command record passed from the front end to the back end.
// No dependencies.
package rpc_pkg;

  localparam int VALUE_W   = 32;
  localparam int BYTE_W    = 8;
  localparam int RUNNING_W = 24;

  // result kinds
  localparam logic KIND_RESIDUAL = 1'b0;
  localparam logic KIND_CONTROL  = 1'b1;

  // value width modes
  localparam logic MODE_16    = 1'b0;
  localparam logic MODE_32    = 1'b1;
  localparam logic MODE_RESET = MODE_32;

  localparam logic [VALUE_W-1:0] HALF_MASK = 32'h0000_FFFF;
  localparam logic [VALUE_W-1:0] FULL_MASK = 32'hFFFF_FFFF;
  localparam logic [BYTE_W-1:0]  BIT_MSB   = 8'h80;

  // result slots of one command, in emission order
  typedef enum logic [1:0] {
    SLOT_R1 = 2'd0,
    SLOT_C1 = 2'd1,
    SLOT_R2 = 2'd2,
    SLOT_C2 = 2'd3
  } slot_t;

  // up to four results caused by one input record
  typedef struct packed {
    logic               last;
    logic               r1_valid;
    logic [VALUE_W-1:0] r1_value;
    logic               c1_valid;
    logic [BYTE_W-1:0]  c1_byte;
    logic               r2_valid;
    logic [VALUE_W-1:0] r2_value;
    logic               c2_valid;
    logic [BYTE_W-1:0]  c2_byte;
  } cmd_t;

endpackage

>>> hw/rtl/reverse_pair_coder.sv
// A record's command passes through the two-entry command queue and the back end's
// command register; results leave one per cycle from the back end's output register
// while the receiver takes them, up to 4 per record over the single result port;
// records with no result are not queued; the queue decouples input and output stalls.
// Reset: synchronous active-low rst_n clears pending record, bit packing, counts and
// queue; value width mode resets to 32-bit.
module reverse_pair_coder #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rpc_pkg::VALUE_W-1:0]   in_first_value,
  input  logic [rpc_pkg::VALUE_W-1:0]   in_second_value,
  input  logic                          in_last_record,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [rpc_pkg::VALUE_W-1:0]   out_value,
  output logic [rpc_pkg::RUNNING_W-1:0] out_running_count,
  output logic                          out_end_of_block,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_value_width_mode
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_not_empty;
  rpc_pkg::cmd_t push_cmd;
  rpc_pkg::cmd_t head_cmd;

  // front end: classification and bit packing
  rpc_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_first_value       (in_first_value),
    .in_second_value      (in_second_value),
    .in_last_record       (in_last_record),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_value_width_mode (cfg_value_width_mode),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_cmd                (push_cmd)
  );

  // command queue
  rpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // back end: result sequencing and counts
  rpc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_head            (head_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_value         (out_value),
    .out_running_count (out_running_count),
    .out_end_of_block  (out_end_of_block)
  );

endmodule

>>> hw/rtl/rpc_front.sv
// rpc_front: accepts records, holds the pending record and the partial
// control byte, and turns each record that causes a result into a command for the back end.
// Depends on rpc_pkg.
module rpc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rpc_pkg::VALUE_W-1:0]   in_first_value,
  input  logic [rpc_pkg::VALUE_W-1:0]   in_second_value,
  input  logic                          in_last_record,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_value_width_mode,
  input  logic                          q_full,
  output logic                          q_push,
  output rpc_pkg::cmd_t                 q_cmd
);

  logic                        mode_r;
  logic                        pend_valid_r, pend_valid_nxt;
  logic [rpc_pkg::VALUE_W-1:0] pend_first_r;
  logic [rpc_pkg::VALUE_W-1:0] pend_second_r;
  logic [rpc_pkg::BYTE_W-1:0]  acc_r, acc_nxt;
  logic [2:0]                  pos_r, pos_nxt;

  logic                        in_fire;
  logic [rpc_pkg::VALUE_W-1:0] mask;
  logic                        match;
  logic                        keep_new;
  logic [rpc_pkg::BYTE_W-1:0]  acc_one;
  logic                        full_one;
  logic [rpc_pkg::BYTE_W-1:0]  acc_a;
  logic [2:0]                  pos_a;
  rpc_pkg::cmd_t               cmd;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_fire   = in_valid && in_ready;

  // classify the record against the pending one
  always_comb begin
    mask     = (mode_r == rpc_pkg::MODE_32) ? rpc_pkg::FULL_MASK : rpc_pkg::HALF_MASK;
    match    = pend_valid_r
               && ((pend_first_r & mask) == (in_second_value & mask))
               && ((pend_second_r & mask) == (in_first_value & mask));
    keep_new = !(pend_valid_r && match);
    acc_one  = acc_r | (match ? (rpc_pkg::BIT_MSB >> pos_r) : '0);
    full_one = (pos_r == 3'd7);
    // packing state after the first control bit
    acc_a    = pend_valid_r ? (full_one ? '0 : acc_one) : acc_r;
    pos_a    = pend_valid_r ? (pos_r + 3'd1) : pos_r;

    cmd.last     = in_last_record;
    cmd.r1_valid = pend_valid_r && !match;
    cmd.r1_value = pend_second_r & mask;
    cmd.c1_valid = pend_valid_r && full_one;
    cmd.c1_byte  = acc_one;
    // lone record at the end of the block
    cmd.r2_valid = in_last_record && keep_new;
    cmd.r2_value = in_second_value & mask;
    // completed byte from the flush bit, or a zero-padded partial byte
    cmd.c2_valid = in_last_record && (keep_new || (pos_a != 3'd0));
    cmd.c2_byte  = acc_a;
  end

  assign q_cmd  = cmd;
  assign q_push = in_fire
                  && (cmd.r1_valid || cmd.c1_valid || cmd.r2_valid || cmd.c2_valid);

  // next packing and pending state
  always_comb begin
    if (in_last_record) begin
      pend_valid_nxt = 1'b0;
      acc_nxt        = '0;
      pos_nxt        = '0;
    end else begin
      pend_valid_nxt = keep_new;
      acc_nxt        = acc_a;
      pos_nxt        = pos_a;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= rpc_pkg::MODE_RESET;
      pend_valid_r <= 1'b0;
      acc_r        <= '0;
      pos_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_value_width_mode;
      end
      if (in_fire) begin
        pend_valid_r <= pend_valid_nxt;
        acc_r        <= acc_nxt;
        pos_r        <= pos_nxt;
      end
    end
  end

  // pending record payload
  always_ff @(posedge clk) begin
    if (in_fire && keep_new) begin
      pend_first_r  <= in_first_value;
      pend_second_r <= in_second_value;
    end
  end

`ifndef ASSERT_OFF
  a_last_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_record) |=> (!pend_valid_r && pos_r == 3'd0 && acc_r == '0))
    else $error("pending state not cleared after end of block");
  a_last_always_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_record) |-> q_push)
    else $error("end of block transaction produced no command");
`endif

endmodule

>>> hw/rtl/rpc_queue.sv
// rpc_queue: two-entry command queue between front end and back end.
// Depends on rpc_pkg.
module rpc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rpc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output rpc_pkg::cmd_t head_cmd
);

  rpc_pkg::cmd_t mem [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_cmd  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("command queue underflow");
`endif

endmodule

>>> hw/rtl/rpc_back.sv
// rpc_back: expands each command into its results, one per cycle while the
// result channel is free, keeps the saturating per-kind counts and drives
// the registered result channel. Depends on rpc_pkg.
module rpc_back #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_not_empty,
  input  rpc_pkg::cmd_t                   q_head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [rpc_pkg::VALUE_W-1:0]     out_value,
  output logic [rpc_pkg::RUNNING_W-1:0]   out_running_count,
  output logic                            out_end_of_block
);

  rpc_pkg::cmd_t                 cmd_r;
  logic [3:0]                    slots_r, slots_nxt;
  logic                          cmd_valid;
  rpc_pkg::slot_t                sel;
  logic [3:0]                    sel_hot;
  logic [3:0]                    slots_left;
  logic                          out_free;
  logic                          emit;

  logic [COUNT_WIDTH-1:0]        res_cnt_r, ctl_cnt_r;
  logic [COUNT_WIDTH-1:0]        res_bump, ctl_bump;

  logic                          out_valid_r;
  logic                          kind_r;
  logic [rpc_pkg::VALUE_W-1:0]   value_r;
  logic [rpc_pkg::RUNNING_W-1:0] running_r;
  logic                          eob_r;

  logic                          e_kind;
  logic [rpc_pkg::VALUE_W-1:0]   e_value;
  logic [COUNT_WIDTH-1:0]        e_count;
  logic [31:0]                   e_count_ext;
  logic                          e_eob;

  assign cmd_valid = (slots_r != 4'd0);
  assign out_free  = !out_valid_r || out_ready;
  assign emit      = cmd_valid && out_free;

  // earliest outstanding slot of the current command
  always_comb begin
    if (slots_r[0]) begin
      sel = rpc_pkg::SLOT_R1;
    end else if (slots_r[1]) begin
      sel = rpc_pkg::SLOT_C1;
    end else if (slots_r[2]) begin
      sel = rpc_pkg::SLOT_R2;
    end else begin
      sel = rpc_pkg::SLOT_C2;
    end
    sel_hot    = 4'd1 << sel;
    slots_left = slots_r & ~sel_hot;
  end

  // saturating counts
  assign res_bump = (res_cnt_r == {COUNT_WIDTH{1'b1}}) ? res_cnt_r : res_cnt_r + 1'b1;
  assign ctl_bump = (ctl_cnt_r == {COUNT_WIDTH{1'b1}}) ? ctl_cnt_r : ctl_cnt_r + 1'b1;

  // result fields for the selected slot
  always_comb begin
    case (sel)
      rpc_pkg::SLOT_R1: begin
        e_kind  = rpc_pkg::KIND_RESIDUAL;
        e_value = cmd_r.r1_value;
      end
      rpc_pkg::SLOT_C1: begin
        e_kind  = rpc_pkg::KIND_CONTROL;
        e_value = {{(rpc_pkg::VALUE_W-rpc_pkg::BYTE_W){1'b0}}, cmd_r.c1_byte};
      end
      rpc_pkg::SLOT_R2: begin
        e_kind  = rpc_pkg::KIND_RESIDUAL;
        e_value = cmd_r.r2_value;
      end
      rpc_pkg::SLOT_C2: begin
        e_kind  = rpc_pkg::KIND_CONTROL;
        e_value = {{(rpc_pkg::VALUE_W-rpc_pkg::BYTE_W){1'b0}}, cmd_r.c2_byte};
      end
      default: begin
        e_kind  = rpc_pkg::KIND_RESIDUAL;
        e_value = '0;
      end
    endcase
    e_count     = (e_kind == rpc_pkg::KIND_CONTROL) ? ctl_bump : res_bump;
    e_count_ext = 32'(e_count);
    e_eob       = cmd_r.last && (slots_left == 4'd0);
  end

  // take the next command once the current one is used up
  assign q_pop = q_not_empty && (!cmd_valid || (emit && slots_left == 4'd0));

  always_comb begin
    slots_nxt = slots_r;
    if (q_pop) begin
      slots_nxt = {q_head.c2_valid, q_head.r2_valid, q_head.c1_valid, q_head.r1_valid};
    end else if (emit) begin
      slots_nxt = slots_left;
    end
  end

  // control state: slots, counts, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r     <= '0;
      res_cnt_r   <= '0;
      ctl_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slots_r <= slots_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
        if (e_eob) begin
          res_cnt_r <= '0;
          ctl_cnt_r <= '0;
        end else if (e_kind == rpc_pkg::KIND_CONTROL) begin
          ctl_cnt_r <= ctl_bump;
        end else begin
          res_cnt_r <= res_bump;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
    if (emit) begin
      kind_r    <= e_kind;
      value_r   <= e_value;
      running_r <= e_count_ext[rpc_pkg::RUNNING_W-1:0];
      eob_r     <= e_eob;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_value         = value_r;
  assign out_running_count = running_r;
  assign out_end_of_block  = eob_r;

`ifndef ASSERT_OFF
  a_eob_clears_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_eob) |=> (res_cnt_r == '0 && ctl_cnt_r == '0))
    else $error("counts not cleared after end of block");
  a_single_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> $onehot(sel_hot & slots_r))
    else $error("selected slot not outstanding");
`endif

endmodule

>>> tb/sv/reverse_pair_coder_tb.sv
// reverse_pair_coder_tb: self-checking testbench for the reverse pair coder.
// Drives records and the width mode, predicts every residual and control byte.
// Depends on rpc_pkg and reverse_pair_coder.
`timescale 1ns / 1ps

typedef struct {
  logic                          kind;
  logic [rpc_pkg::VALUE_W-1:0]   value;
  logic [rpc_pkg::RUNNING_W-1:0] count;
  logic                          eob;
} coded_result_t;

// Predicts the coded stream and checks the block's results against it
class pair_code_scoreboard;
  localparam int COUNT_W = 24;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  coded_result_t expected_codes[$];
  logic                        mode;
  logic                        pend_valid;
  logic [rpc_pkg::VALUE_W-1:0] pend_first;
  logic [rpc_pkg::VALUE_W-1:0] pend_second;
  logic [7:0]                  ctl_byte;
  logic [2:0]                  ctl_pos;
  logic [COUNT_W-1:0]          residual_total;
  logic [COUNT_W-1:0]          control_total;
  int unsigned                 mismatches;
  int unsigned                 records;
  int unsigned                 results;
  int unsigned                 swaps;

  function new();
    mode           = rpc_pkg::MODE_RESET;
    pend_valid     = 1'b0;
    pend_first     = '0;
    pend_second    = '0;
    ctl_byte       = '0;
    ctl_pos        = '0;
    residual_total = '0;
    control_total  = '0;
    mismatches     = 0;
    records        = 0;
    results        = 0;
    swaps          = 0;
  endfunction

  function void set_mode(logic m);
    mode = m;
  endfunction

  function int outstanding();
    return expected_codes.size();
  endfunction

  function logic [rpc_pkg::VALUE_W-1:0] width_mask();
    return (mode == rpc_pkg::MODE_32) ? rpc_pkg::FULL_MASK : rpc_pkg::HALF_MASK;
  endfunction

  // queue one result and bump the count of its kind
  function void emit(logic kind, logic [rpc_pkg::VALUE_W-1:0] value);
    coded_result_t r;
    if (kind == rpc_pkg::KIND_CONTROL) begin
      if (control_total != COUNT_MAX) control_total = control_total + 1'b1;
      r.count = control_total[rpc_pkg::RUNNING_W-1:0];
    end else begin
      if (residual_total != COUNT_MAX) residual_total = residual_total + 1'b1;
      r.count = residual_total[rpc_pkg::RUNNING_W-1:0];
    end
    r.kind  = kind;
    r.value = value;
    r.eob   = 1'b0;
    expected_codes.push_back(r);
  endfunction

  // MSB-first bit packing, full byte goes out at once
  function void pack_bit(logic b);
    if (b) ctl_byte = ctl_byte | (rpc_pkg::BIT_MSB >> ctl_pos);
    if (ctl_pos == 3'd7) begin
      emit(rpc_pkg::KIND_CONTROL, {24'd0, ctl_byte});
      ctl_byte = '0;
    end
    ctl_pos = ctl_pos + 3'd1;
  endfunction

  // one accepted record transaction
  function void note_record(logic [rpc_pkg::VALUE_W-1:0] a, logic [rpc_pkg::VALUE_W-1:0] b,
                            logic last);
    logic [rpc_pkg::VALUE_W-1:0] m;
    int                          before_n;
    m        = width_mask();
    before_n = expected_codes.size();
    records++;
    if (pend_valid) begin
      if (((pend_first & m) == (b & m)) && ((pend_second & m) == (a & m))) begin
        pend_valid = 1'b0;
        swaps++;
        pack_bit(1'b1);
      end else begin
        emit(rpc_pkg::KIND_RESIDUAL, pend_second & m);
        pend_first  = a;
        pend_second = b;
        pack_bit(1'b0);
      end
    end else begin
      pend_valid  = 1'b1;
      pend_first  = a;
      pend_second = b;
    end
    if (last) begin
      // lone record, then partial byte, then restart the block
      if (pend_valid) begin
        emit(rpc_pkg::KIND_RESIDUAL, pend_second & m);
        pend_valid = 1'b0;
        pack_bit(1'b0);
      end
      if (ctl_pos != 3'd0) emit(rpc_pkg::KIND_CONTROL, {24'd0, ctl_byte});
      if (expected_codes.size() > before_n)
        expected_codes[expected_codes.size()-1].eob = 1'b1;
      pend_first     = '0;
      pend_second    = '0;
      ctl_byte       = '0;
      ctl_pos        = '0;
      residual_total = '0;
      control_total  = '0;
    end
  endfunction

  task report(string what);
    mismatches++;
    if (mismatches <= 40) $display("ERROR @%0t: %s", $time, what);
  endtask

  // one accepted result transaction
  task check_result(logic kind, logic [rpc_pkg::VALUE_W-1:0] value,
                    logic [rpc_pkg::RUNNING_W-1:0] count, logic eob);
    coded_result_t e;
    results++;
    if (expected_codes.size() == 0) begin
      report($sformatf("result with nothing expected: kind %0d value %h", kind, value));
    end else begin
      e = expected_codes.pop_front();
      if (kind !== e.kind)
        report($sformatf("kind %b, expected %b", kind, e.kind));
      if (value !== e.value)
        report($sformatf("value %h, expected %h", value, e.value));
      if (count !== e.count)
        report($sformatf("running count %0d, expected %0d", count, e.count));
      if (eob !== e.eob)
        report($sformatf("end of block %b, expected %b", eob, e.eob));
    end
  endtask
endclass

module reverse_pair_coder_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 400;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [rpc_pkg::VALUE_W-1:0]   in_first_value;
  logic [rpc_pkg::VALUE_W-1:0]   in_second_value;
  logic                          in_last_record;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_kind;
  logic [rpc_pkg::VALUE_W-1:0]   out_value;
  logic [rpc_pkg::RUNNING_W-1:0] out_running_count;
  logic                          out_end_of_block;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic                          cfg_value_width_mode;

  pair_code_scoreboard sb;
  int                  tx_idle_pct;
  int                  rx_stall_pct;
  bit                  hold_go;
  int unsigned         cycle_count;
  int unsigned         mode_writes;

  reverse_pair_coder #(.COUNT_WIDTH(24)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_first_value       (in_first_value),
    .in_second_value      (in_second_value),
    .in_last_record       (in_last_record),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_value            (out_value),
    .out_running_count    (out_running_count),
    .out_end_of_block     (out_end_of_block),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_value_width_mode (cfg_value_width_mode)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_kind, out_value, out_running_count, out_end_of_block);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        out_ready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
        hold_go = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // one record transaction, with random idle cycles ahead of it
  task automatic send_record(logic [rpc_pkg::VALUE_W-1:0] a, logic [rpc_pkg::VALUE_W-1:0] b,
                             logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_first_value  <= a;
    in_second_value <= b;
    in_last_record  <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_record(a, b, last);
  endtask

  // let the block empty out before touching the mode
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_valid            <= 1'b1;
    cfg_value_width_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_mode(m);
    mode_writes++;
  endtask

  function automatic logic [rpc_pkg::VALUE_W-1:0] rand_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 12) return ($urandom_range(1) != 0) ? rpc_pkg::FULL_MASK : '0;
    if (sel < 25) return rpc_pkg::VALUE_W'($urandom_range(3));
    return $urandom;
  endfunction

  // mostly swapped partners of the held record, some near misses, some noise
  task automatic send_random();
    logic [rpc_pkg::VALUE_W-1:0] a;
    logic [rpc_pkg::VALUE_W-1:0] b;
    int                          sel;
    int                          idx;
    sel = $urandom_range(99);
    idx = $urandom_range(31);
    if (sb.pend_valid && sel < 55) begin
      a = sb.pend_second;
      b = sb.pend_first;
      // upper halves are don't-care in 16-bit mode
      if (sb.mode == rpc_pkg::MODE_16 && $urandom_range(1) != 0) begin
        a[31:16] = 16'($urandom);
        b[31:16] = 16'($urandom);
      end
    end else if (sb.pend_valid && sel < 67) begin
      a = sb.pend_second;
      b = sb.pend_first;
      if ($urandom_range(1) != 0) a[idx] = ~a[idx];
      else b[idx % 16] = ~b[idx % 16];
    end else begin
      a = rand_value();
      b = rand_value();
    end
    send_record(a, b, $urandom_range(11) == 0);
  endtask

  task automatic run_phase(int n, int tx_pct, int rx_pct, logic m);
    drain();
    write_mode(m);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (n) send_random();
  endtask

  initial begin
    sb           = new();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_go      = 1'b0;
    cycle_count  = 0;
    mode_writes  = 0;
    rst_n                <= 1'b0;
    in_valid             <= 1'b0;
    in_first_value       <= '0;
    in_second_value      <= '0;
    in_last_record       <= 1'b0;
    cfg_valid            <= 1'b0;
    cfg_value_width_mode <= rpc_pkg::MODE_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 32-bit mode
    write_mode(rpc_pkg::MODE_32);
    // lone record at block end
    send_record(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    // swapped pair, partial control byte flushed
    send_record(32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
    send_record(32'h9ABC_DEF0, 32'h1234_5678, 1'b1);
    // nine unmatched records: the last one closes a full byte, then emits the
    // lone residual and a partial byte, four results in all
    send_record(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    send_record(32'h0000_0001, 32'hFFFF_FFFE, 1'b0);
    send_record(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_record(32'h7FFF_FFFF, 32'h8000_0001, 1'b0);
    send_record(32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
    send_record(32'h5A5A_5A5A, 32'hA5A5_A5A4, 1'b0);
    send_record(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_record(32'h0000_0002, 32'h0000_0003, 1'b1);

    // directed: 16-bit mode, upper halves ignored and masked off
    drain();
    write_mode(rpc_pkg::MODE_16);
    send_record(32'h1111_AAAA, 32'h2222_BBBB, 1'b0);
    send_record(32'h9999_BBBB, 32'h7777_AAAA, 1'b0);
    send_record(32'hFFFF_FFFF, 32'hFFFF_0000, 1'b0);
    send_record(32'h0000_FFFF, 32'h0001_FFFF, 1'b0);
    send_record(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_record(32'hFFFF_0000, 32'h0000_0000, 1'b1);
    // mode change with a record held: 16-bit match, 32-bit miss
    send_record(32'h0001_0005, 32'h0002_0006, 1'b0);
    drain();
    write_mode(rpc_pkg::MODE_32);
    send_record(32'h0003_0006, 32'h0004_0005, 1'b1);

    // random phases
    run_phase(110, 0, 0, rpc_pkg::MODE_32);
    run_phase(90, 87, 0, rpc_pkg::MODE_16);
    run_phase(90, 0, 87, rpc_pkg::MODE_32);
    run_phase(110, 37, 37, rpc_pkg::MODE_16);

    // output held off long enough to back the block up
    drain();
    write_mode(rpc_pkg::MODE_32);
    tx_idle_pct  = 0;
    rx_stall_pct = 10;
    hold_go      = 1'b1;
    repeat (80) send_random();

    drain();
    $display("Sent %0d records (%0d swapped pairs) in both widths over %0d mode writes,",
             sb.records, sb.swaps, mode_writes);
    $display("checked %0d results under idle, stall and long back-pressure phases.",
             sb.results);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
